// File: rtl/pcodec_pkg.sv
// Shared types, constants and character helpers for the percent codec.
// No dependencies; imported by every module of the block.
`default_nettype none

package pcodec_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    // Index by nibble value: HEX_UPPER[n] is the uppercase digit for n
    localparam logic [15:0][7:0] HEX_UPPER = "FEDCBA9876543210";

    // Decode hold state codes
    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    // Up to three output bytes caused by one input transaction
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
        logic            last;
    } burst_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t r;
        r.valid = 1'b1;
        r.value = 4'd0;
        if (c >= "0" && c <= "9")
        begin
            r.value = c[3:0];
        end
        else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
        begin
            r.value = c[3:0] + 4'd9;
        end
        else
        begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == "-" || c == "." ||
               c == "_" || c == "~";
    endfunction

endpackage

`default_nettype wire

// File: rtl/pcodec_front.sv
// Front end of the percent codec: accepts input bytes, tracks the decode
// hold state and the mode register, and turns each byte into a burst.
// Depends on pcodec_pkg.
`default_nettype none

module pcodec_front
    import pcodec_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            push,
    output burst_t          push_data,
    input  wire logic       queue_full
);

    logic       decode_mode_reg;
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [7:0] held_digit_reg;
    logic [7:0] held_digit_next;
    logic       accept;
    burst_t     burst;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign push      = accept && (burst.count != 2'd0);
    assign push_data = burst;

    always_comb
    begin
        hex_t       hb;
        hex_t       hd;
        logic [1:0] n;
        hb = hex_value(in_byte);
        hd = hex_value(held_digit_reg);
        n = 2'd0;
        burst = '0;
        held_count_next = held_count_reg;
        held_digit_next = held_digit_reg;

        if (!decode_mode_reg)
        begin
            // Encode: drop anything held
            held_count_next = HELD_NONE;
            held_digit_next = 8'h00;
            if (is_unreserved(in_byte))
            begin
                burst.bytes[0] = in_byte;
                n = 2'd1;
            end
            else
            begin
                burst.bytes[0] = PCT_CHAR;
                burst.bytes[1] = HEX_UPPER[in_byte[7:4]];
                burst.bytes[2] = HEX_UPPER[in_byte[3:0]];
                n = 2'd3;
            end
        end
        else
        begin
            case (held_count_reg)
                HELD_PCT:
                begin
                    if (hb.valid)
                    begin
                        held_count_next = HELD_DIGIT;
                        held_digit_next = in_byte;
                    end
                    else
                    begin
                        burst.bytes[0] = PCT_CHAR;
                        n = 2'd1;
                        held_count_next = HELD_NONE;
                        if (in_byte == PCT_CHAR)
                        begin
                            held_count_next = HELD_PCT;
                        end
                        else
                        begin
                            burst.bytes[1] = in_byte;
                            n = 2'd2;
                        end
                    end
                end
                HELD_DIGIT:
                begin
                    held_count_next = HELD_NONE;
                    held_digit_next = 8'h00;
                    if (hb.valid)
                    begin
                        burst.bytes[0] = {(hd.valid ? hd.value : 4'd0), hb.value};
                        n = 2'd1;
                    end
                    else
                    begin
                        burst.bytes[0] = PCT_CHAR;
                        burst.bytes[1] = held_digit_reg;
                        n = 2'd2;
                        if (in_byte == PCT_CHAR)
                        begin
                            held_count_next = HELD_PCT;
                        end
                        else
                        begin
                            burst.bytes[2] = in_byte;
                            n = 2'd3;
                        end
                    end
                end
                default:
                begin
                    held_count_next = HELD_NONE;
                    if (in_byte == PCT_CHAR)
                    begin
                        held_count_next = HELD_PCT;
                    end
                    else
                    begin
                        burst.bytes[0] = in_byte;
                        n = 2'd1;
                    end
                end
            endcase
        end

        // End of string: flush the held bytes literally
        if (in_last)
        begin
            if (held_count_next == HELD_PCT || held_count_next == HELD_DIGIT)
            begin
                burst.bytes[n] = PCT_CHAR;
                n = n + 2'd1;
            end
            if (held_count_next == HELD_DIGIT)
            begin
                burst.bytes[n] = held_digit_next;
                n = n + 2'd1;
            end
            held_count_next = HELD_NONE;
            held_digit_next = 8'h00;
            burst.last = 1'b1;
        end
        burst.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= 1'b0;
            held_count_reg  <= HELD_NONE;
            held_digit_reg  <= 8'h00;
        end
        else
        begin
            if (cfg_we)
            begin
                decode_mode_reg <= cfg_wdata;
            end
            if (accept)
            begin
                held_count_reg <= held_count_next;
                held_digit_reg <= held_digit_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_held_reachable: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd3)
        else $error("front: hold count reached an unused code");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> held_count_reg == HELD_NONE)
        else $error("front: hold state survived end of string");
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |-> push)
        else $error("front: end of string produced no output");
`endif

endmodule

`default_nettype wire

// File: rtl/pcodec_queue.sv
// Short register queue of bursts between the front and back ends.
// Depends on pcodec_pkg for the burst type.
`default_nettype none

module pcodec_queue
    import pcodec_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire burst_t push_data,
    output logic        full,
    input  wire logic   pop,
    output logic        not_empty,
    output burst_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    burst_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;

    assign full      = cnt_reg == CNT_W'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head      = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= advance(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= advance(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue: push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("queue: pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue: fill count beyond depth");
`endif

endmodule

`default_nettype wire

// File: rtl/pcodec_back.sv
// Back end of the percent codec: serializes queued bursts one byte per
// cycle while out_ready lets it, into a registered output stage. Depends on pcodec_pkg.
`default_nettype none

module pcodec_back
    import pcodec_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  wire burst_t     head,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [1:0] idx_reg;
    logic       load;
    logic       final_byte;

    assign load       = head_valid && (!out_valid_reg || out_ready);
    assign final_byte = idx_reg == (head.count - 2'd1);
    assign pop        = load && final_byte;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= head.bytes[idx_reg];
            out_last_reg <= head.last && final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= final_byte ? 2'd0 : idx_reg + 2'd1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> head.count != 2'd0)
        else $error("back: queued burst carries no bytes");
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg < head.count)
        else $error("back: byte index past end of burst");
    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> idx_reg == 2'd0)
        else $error("back: byte index left mid-burst");
`endif

endmodule

`default_nettype wire

// File: rtl/percent_encode_decode_codec.sv
// Top level of the URL percent encoder/decoder.
// Depends on pcodec_pkg, pcodec_front, pcodec_queue and pcodec_back.
//
// Usage:
//   Slave stream (s_*): one source byte per transaction in s_tdata, with
//   s_tlast on the final byte of a string. Master stream (m_*): one output
//   byte per transaction in m_tdata, with m_tlast on the final output byte
//   caused by a string's last input byte.
//   cfg_we/cfg_wdata write decode_mode (0 encode, 1 decode); write it only
//   while the block is idle. The held decode state is untouched by a write.
// Path: the first output byte of an input transaction is written into the
//   burst queue at the accepting edge, then loaded into the one output
//   register that drives m_tvalid; an output stall can hold it in the queue.
// Throughput: each input takes as many output transactions as the bytes it
//   causes: one for a passed byte, three for an encoded escape, zero for a
//   held escape prefix. The byte-wide output register sets this limit; an
//   input can follow on every cycle while the output keeps pace.
// Reset: rst_n clears the mode to encode, the hold state, the queue and the
//   output valid.
// Stall: while m_tready is low the output register holds its transaction;
//   the queue keeps taking inputs until full, then s_tready drops.
`default_nettype none

module percent_encode_decode_codec
    import pcodec_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,      // decode_mode
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,        // [7:0] data_byte
    input  wire logic       s_tlast,        // last_in
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,        // [7:0] out_byte
    output logic            m_tlast         // out_last
);

    logic   push;
    burst_t push_data;
    logic   queue_full;
    logic   pop;
    logic   head_valid;
    burst_t head;

    // Classify the byte, update the hold state, build its burst
    pcodec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    // Decouple the front from output stalls
    pcodec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (head_valid),
        .head      (head)
    );

    // Emit each burst one byte per transaction
    pcodec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

`default_nettype wire
